FILE: src/keyed_record_table_unit_defines.svh
// assertion macros shared by the checker
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define KRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define KRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/krt_pkg.sv
package krt_pkg;

    localparam logic [7:0] OP_ADD = 8'd1;
    localparam logic [7:0] OP_DEL = 8'd2;
    localparam logic [7:0] OP_GET = 8'd3;
    localparam logic [7:0] OP_MOD = 8'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam int NAME_BYTES = 30;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int REC_W      = 32 + NAME_W + 32 + 32;
    localparam logic [7:0] LIMIT_RESET = 8'd100;

    typedef enum logic [2:0] {
        K_ADD,
        K_DEL,
        K_GET,
        K_MOD,
        K_BAD
    } kind_t;

    typedef struct packed {
        logic signed [31:0] phone;
        logic signed [31:0] salary;
        logic [NAME_W-1:0]  name;
        logic signed [31:0] id;
    } rec_t;

    typedef struct packed {
        kind_t kind;
        rec_t  rec;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

endpackage

FILE: src/keyed_record_table_unit.sv
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tuser op, s_tdata record fields
// m_        out        m_tvalid / m_tready  m_tuser status, m_tdata found record
// cfg_      in         cfg_valid / cfg_ready cfg_data record_limit
//
// add and invalid: executed without a table scan
// get, modify, delete: scan entries newest first, one record memory read port
// delete then moves each later entry down by one to close the gap
// synchronous active-low reset empties the table at once, limit returns to 100
// a two-entry command queue and the output register let input and output stall apart
module keyed_record_table_unit
    import krt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tuser,  // op
    input  logic [REC_W-1:0] s_tdata,  // rec_id, name (30 bytes), salary_in, phone_in
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [1:0]       m_tuser,  // result_status
    output logic [REC_W-1:0] m_tdata,  // found_id, found_name (30 bytes), found_salary, found_phone
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data  // record_limit
);

    logic [7:0] limit_reg, limit_next;
    cmd_t       front_cmd;
    cmd_t       q_head;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    rec_t       out_rec;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;
    assign s_tready   = !q_full;
    assign m_tdata    = REC_W'(out_rec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    krt_front u_front (
        .op  (s_tuser),
        .raw (s_tdata),
        .cmd (front_cmd)
    );

    krt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && s_tready),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    krt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .limit      (limit_reg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_status (m_tuser),
        .out_rec    (out_rec),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

endmodule

FILE: src/krt_front.sv
module krt_front
    import krt_pkg::*;
(
    input  logic [7:0]       op,
    input  logic [REC_W-1:0] raw,
    output cmd_t             cmd
);

    logic [NAME_W-1:0] name_tidy;
    logic              ended;
    rec_t              rec_in;

    assign rec_in = rec_t'(raw);

    // zero every byte after the terminator
    always_comb begin
        name_tidy = rec_in.name;
        ended     = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (ended) begin
                name_tidy[8*b +: 8] = 8'd0;
            end else if (rec_in.name[8*b +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
    end

    always_comb begin
        cmd.rec      = rec_in;
        cmd.rec.name = name_tidy;
        unique case (op)
            OP_ADD:  cmd.kind = K_ADD;
            OP_DEL:  cmd.kind = K_DEL;
            OP_GET:  cmd.kind = K_GET;
            OP_MOD:  cmd.kind = K_MOD;
            default: cmd.kind = K_BAD;
        endcase
    end

endmodule

FILE: src/krt_queue.sv
module krt_queue
    import krt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  cmd_t   push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output cmd_t   head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/krt_back.sv
module krt_back
    import krt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] limit,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic [1:0] out_status,
    output rec_t       out_rec,
    output logic       out_valid,
    input  logic       out_ready
);

    krt_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .limit      (limit),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_status (out_status),
        .out_rec    (out_rec),
        .out_ready  (out_ready)
    );

endmodule

FILE: src/krt_exec.sv
module krt_exec
    import krt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] limit,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    output logic [1:0] out_status,
    output rec_t       out_rec,
    input  logic       out_ready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 8) ? CW : 8;

    rec_t mem [CAPACITY];
    rec_t rd_data_reg;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [1:0]      res_st_reg, res_st_next;
    rec_t            res_rec_reg, res_rec_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_st_reg, out_st_next;
    rec_t            out_rec_reg, out_rec_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    rec_t            wr_data;
    logic [AW-1:0]   rd_addr;
    logic            no_space;
    logic            hit;
    logic            out_free;
    logic            last_hit;
    logic            last_shift;

    assign no_space   = (LW'(count_reg) >= LW'(limit)) || (LW'(count_reg) >= LW'(CAPACITY));
    assign hit        = (rd_data_reg.id == cmd_reg.rec.id);
    assign out_free   = !out_valid_reg || out_ready;
    assign last_hit   = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign last_shift = ((CW'(idx_reg) + CW'(2)) == count_reg);

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign out_valid  = out_valid_reg;
    assign out_status = out_st_reg;
    assign out_rec    = out_rec_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_EXEC;
            S_EXEC: begin
                unique case (cmd_reg.kind)
                    K_ADD, K_BAD: state_next = S_DONE;
                    default:      state_next = (count_reg == '0) ? S_DONE : S_RD;
                endcase
            end
            S_RD:    state_next = S_CMP;
            S_CMP: begin
                if (hit) begin
                    state_next = (cmd_reg.kind == K_DEL && !last_hit) ? S_SH_RD : S_DONE;
                end else begin
                    state_next = (idx_reg == '0) ? S_DONE : S_RD;
                end
            end
            S_SH_RD: state_next = S_SH_WR;
            S_SH_WR: state_next = last_shift ? S_DONE : S_SH_RD;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_st_next    = res_st_reg;
        res_rec_next   = res_rec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_st_next    = out_st_reg;
        out_rec_next   = out_rec_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = cmd_reg.rec;
        rd_addr        = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) cmd_next = q_head;
                res_rec_next = '0;
            end
            S_EXEC: begin
                unique case (cmd_reg.kind)
                    K_ADD: begin
                        if (no_space) begin
                            res_st_next = ST_NOSPACE;
                        end else begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[AW-1:0];
                            count_next  = count_reg + CW'(1);
                            res_st_next = ST_OK;
                        end
                    end
                    K_BAD: res_st_next = ST_INVALID;
                    default: begin
                        res_st_next = ST_NOTFOUND;
                        idx_next    = AW'(count_reg - CW'(1));
                    end
                endcase
            end
            S_RD: rd_addr = idx_reg;
            S_CMP: begin
                if (hit) begin
                    res_st_next = ST_OK;
                    unique case (cmd_reg.kind)
                        K_GET: res_rec_next = rd_data_reg;
                        K_MOD: wr_en = 1'b1;
                        K_DEL: if (last_hit) count_next = count_reg - CW'(1);
                        default: res_st_next = ST_OK;
                    endcase
                end else if (idx_reg != '0) begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_SH_RD: rd_addr = idx_reg + AW'(1);
            S_SH_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if (last_shift) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_rec_next   = res_rec_reg;
                end
            end
            default: res_st_next = res_st_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        res_st_reg  <= res_st_next;
        res_rec_reg <= res_rec_next;
        out_st_reg  <= out_st_next;
        out_rec_reg <= out_rec_next;
    end

endmodule

FILE: src/krt_checker.sv
`include "keyed_record_table_unit_defines.svh"

module krt_checker
    import krt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [7:0]       s_tuser,
    input logic [REC_W-1:0] s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [1:0]       m_tuser,
    input logic [REC_W-1:0] m_tdata,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [7:0]       cfg_data
);

    `KRT_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `KRT_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `KRT_ASSERT_NOW(a_zero_fields, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `KRT_ASSERT_NOW(a_quiet_after_reset, aclk, aresetn, $past(!aresetn), !m_tvalid)

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);
